// ----- sv/klk_pkg.sv -----
package klk_pkg;

   localparam int unsigned KEY_W      = 8;
   localparam int unsigned PASSCODE_W = 32;
   localparam int unsigned TICKS_W    = 12;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned POS_OUT_W  = 2;

   localparam logic [KEY_W-1:0]      KEY_CLEAR      = 8'h23;  // '#'
   localparam logic [KEY_W-1:0]      KEY_ENTER      = 8'h2A;  // '*'
   localparam logic [PASSCODE_W-1:0] PASSCODE_RESET = 32'h3132_3233;
   localparam logic [TICKS_W-1:0]    LOCKOUT_RESET  = 12'd2000;

   localparam logic [CSR_IDX_W-1:0] CSR_PASSCODE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_TICKS = 1'b1;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_STORED   = 3'd1,
      EV_CLEARED  = 3'd2,
      EV_ACCEPTED = 3'd3,
      EV_REJECTED = 3'd4,
      EV_EXPIRED  = 3'd5
   } event_type;

   typedef struct packed {
      event_type              event_res;
      logic [POS_OUT_W-1:0]   next_position;
      logic                   entry_complete;
      logic                   unlocked;
      logic                   lockout_active;
   } result_type;

endpackage

// ----- sv/klk_core.sv -----
module klk_core #(
   parameter int unsigned CODE_LENGTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [klk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [klk_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                        fire,
   input  logic                        opcode,
   input  logic [klk_pkg::KEY_W-1:0]   key_code,
   output klk_pkg::result_type         result
);
   import klk_pkg::*;

   localparam int unsigned PW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam logic [PW-1:0] LAST_POS = PW'(CODE_LENGTH - 1);

   logic [PASSCODE_W-1:0] passcode_ff;
   logic [TICKS_W-1:0]    lockout_ticks_ff;

   logic [KEY_W-1:0] keys_ff [CODE_LENGTH];
   logic [KEY_W-1:0] keys_in [CODE_LENGTH];
   logic [KEY_W-1:0] want    [CODE_LENGTH];
   logic [PW-1:0]      pos_ff, pos_in;
   logic               complete_ff, complete_in;
   logic               unlocked_ff, unlocked_in;
   logic               lockout_ff, lockout_in;
   logic [TICKS_W-1:0] count_ff, count_in, count_inc;
   logic [CODE_LENGTH-1:0] byte_eq;
   logic               match;
   event_type          ev;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         passcode_ff      <= PASSCODE_RESET;
         lockout_ticks_ff <= LOCKOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PASSCODE:      passcode_ff      <= csr_write_data;
            CSR_LOCKOUT_TICKS: lockout_ticks_ff <= csr_write_data[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // passcode byte for each slot, first key in the top byte; bytes past 32 bits read zero
   for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_want
      if (CODE_LENGTH - 1 - g < PASSCODE_W / KEY_W) begin : g_in
         assign want[g] = passcode_ff[KEY_W*(CODE_LENGTH-1-g) +: KEY_W];
      end else begin : g_zero
         assign want[g] = '0;
      end
      assign byte_eq[g] = (keys_ff[g] == want[g]);
   end

   assign match     = &byte_eq;
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      keys_in     = keys_ff;
      pos_in      = pos_ff;
      complete_in = complete_ff;
      unlocked_in = unlocked_ff;
      lockout_in  = lockout_ff;
      count_in    = count_ff;
      ev          = EV_NONE;
      if (unlocked_ff) begin
         ev = EV_NONE;
      end else if (opcode == OP_TICK) begin
         if (lockout_ff) begin
            count_in = count_inc;
            if (count_inc >= lockout_ticks_ff) begin
               pos_in      = '0;
               complete_in = 1'b0;
               lockout_in  = 1'b0;
               count_in    = '0;
               ev          = EV_EXPIRED;
            end
         end
      end else if (key_code == KEY_CLEAR) begin
         pos_in      = '0;
         complete_in = 1'b0;
         lockout_in  = 1'b0;
         count_in    = '0;
         ev          = EV_CLEARED;
      end else if (key_code == KEY_ENTER) begin
         if (complete_ff) begin
            lockout_in = !match;
            count_in   = '0;
            if (match) begin
               unlocked_in = 1'b1;
               ev          = EV_ACCEPTED;
            end else begin
               ev = EV_REJECTED;
            end
         end
      end else begin
         for (int i = 0; i < CODE_LENGTH; i++) begin
            if (pos_ff == PW'(i)) keys_in[i] = key_code;
         end
         if (pos_ff == LAST_POS) begin
            pos_in      = '0;
            complete_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
         ev = EV_STORED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         complete_ff <= 1'b0;
         unlocked_ff <= 1'b0;
         lockout_ff  <= 1'b0;
         count_ff    <= '0;
      end else if (fire) begin
         pos_ff      <= pos_in;
         complete_ff <= complete_in;
         unlocked_ff <= unlocked_in;
         lockout_ff  <= lockout_in;
         count_ff    <= count_in;
      end
   end

   // key slots hold no reset: a slot is always rewritten before a compare reads it
   always_ff @(posedge clock) begin
      if (fire) keys_ff <= keys_in;
   end

   always_comb begin
      result.event_res      = ev;
      result.next_position  = POS_OUT_W'(pos_in);
      result.entry_complete = complete_in;
      result.unlocked       = unlocked_in;
      result.lockout_active = lockout_in;
   end

endmodule

// ----- sv/keypad_code_lock.sv -----
// Channel   Dir  Handshake            Payload
// req_      in   req_valid/req_ready  req_opcode, req_key_code
// rsp_      out  rsp_valid/rsp_ready  rsp_event_res, rsp_next_position, rsp_entry_complete,
//                                     rsp_unlocked, rsp_lockout_active
// csr_      in   csr_write_enable     csr_index, csr_write_data (no read-back)
//
// One item per cycle sustained while rsp_ready is high; each item gives exactly one result,
// shown on rsp_valid once it has passed the input register (loaded at the accepting edge)
// and the state update into the result register (taken when that register is free).
// Reset (synchronous, active high) clears the lock state and loads the passcode
// "1223" and a lockout of 2000 ticks.
// A stalled result holds the result register; the input register still takes an
// item, and req_ready drops only when both registers are full and rsp_ready is low.
module keypad_code_lock #(
   parameter int unsigned CODE_LENGTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_opcode,
   input  logic [klk_pkg::KEY_W-1:0]      req_key_code,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_event_res,
   output logic [1:0]                     rsp_next_position,
   output logic                           rsp_entry_complete,
   output logic                           rsp_unlocked,
   output logic                           rsp_lockout_active,
   input  logic                           csr_write_enable,
   input  logic [klk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [klk_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import klk_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic             in_opcode_ff;
   logic [KEY_W-1:0] in_key_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, step_result;
   logic             req_fire, out_free, advance;

   // advance the held item whenever the result register is empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register: load the item on acceptance
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_opcode_ff <= req_opcode;
         in_key_ff    <= req_key_code;
      end
   end

   klk_core #(
      .CODE_LENGTH(CODE_LENGTH)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fire             (advance),
      .opcode           (in_opcode_ff),
      .key_code         (in_key_ff),
      .result           (step_result)
   );

   // result register: capture the post-update status with the event
   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= step_result;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_ff.event_res;
   assign rsp_next_position  = rsp_ff.next_position;
   assign rsp_entry_complete = rsp_ff.entry_complete;
   assign rsp_unlocked       = rsp_ff.unlocked;
   assign rsp_lockout_active = rsp_ff.lockout_active;

endmodule

// ----- sv/klk_checker.sv -----
module klk_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_res,
   input logic [1:0] rsp_next_position,
   input logic       rsp_entry_complete,
   input logic       rsp_unlocked,
   input logic       rsp_lockout_active
);
   import klk_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_next_position) && $stable(rsp_entry_complete))
      else $error("result changed while stalled");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_ACCEPTED
         |-> rsp_unlocked && !rsp_lockout_active && rsp_entry_complete)
      else $error("accept without unlock");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_REJECTED
         |-> rsp_lockout_active && rsp_entry_complete && !rsp_unlocked)
      else $error("reject without lockout");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_CLEARED || rsp_event_res == EV_EXPIRED)
         |-> rsp_next_position == 2'd0 && !rsp_entry_complete && !rsp_lockout_active)
      else $error("clear left entry state behind");

endmodule

bind keypad_code_lock klk_checker u_klk_checker (.*);
